[hw/rtl/bdsl_pkg.sv]
// shared types and constants for the button debounce / short-long press block
// no dependencies
package bdsl_pkg;

    localparam int unsigned DEBOUNCE_W = 8;
    localparam int unsigned LONG_W     = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd50;
    localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd3000;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 1'b1;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESSED = 3'd1,
        EV_SHORT   = 3'd2,
        EV_LONG    = 3'd3,
        EV_ARMED   = 3'd4
    } event_t;

    // item held in the input register, handed to the core
    typedef struct packed {
        logic valid;
        logic button;
    } stage_t;

endpackage

[hw/rtl/bdsl_in_stage.sv]
// input register stage: captures one tick transfer and holds it for the core
// depends on bdsl_pkg
module bdsl_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              button_down,
    input  logic              take,
    output bdsl_pkg::stage_t  item
);

    logic valid_reg;
    logic valid_next;
    logic button_reg;
    logic accept;

    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            button_reg <= button_down;
        end
    end

    assign item.valid  = valid_reg;
    assign item.button = button_reg;

endmodule

[hw/rtl/bdsl_core.sv]
// debounce and press-classification state plus the result register
// depends on bdsl_pkg
module bdsl_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bdsl_pkg::stage_t                    item,
    output logic                                take,
    input  logic                                cfg_we,
    input  logic [bdsl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdsl_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          event_res,
    output logic [15:0]                         held_ms,
    output logic                                stable_level
);

    // configuration
    logic [bdsl_pkg::DEBOUNCE_W-1:0] debounce_reg;
    logic [bdsl_pkg::LONG_W-1:0]     long_reg;

    // tick state
    logic        started_reg,  started_next;
    logic        last_reg,     last_next;
    logic        stable_reg,   stable_next;
    logic [7:0]  quiet_reg,    quiet_next;
    logic [15:0] press_reg,    press_next;
    logic        long_done_reg, long_done_next;
    logic        armed_reg,    armed_next;

    // result
    logic             res_valid_reg, res_valid_next;
    bdsl_pkg::event_t ev_reg, ev_next;

    logic        raw;
    logic [15:0] press_inc;
    logic [7:0]  quiet_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= bdsl_pkg::DEBOUNCE_RESET;
            long_reg     <= bdsl_pkg::LONG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdsl_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data[bdsl_pkg::DEBOUNCE_W-1:0];
                bdsl_pkg::CFG_LONG:     long_reg     <= cfg_data[bdsl_pkg::LONG_W-1:0];
                default:                ;
            endcase
        end
    end

    assign take = item.valid && (!res_valid_reg || !out_stall);
    assign raw  = item.button;

    assign press_inc = (press_reg == 16'hFFFF) ? press_reg : press_reg + 16'd1;
    assign quiet_inc = (quiet_reg == 8'hFF) ? quiet_reg : quiet_reg + 8'd1;

    always_comb
    begin
        started_next   = started_reg;
        last_next      = last_reg;
        stable_next    = stable_reg;
        quiet_next     = quiet_reg;
        press_next     = press_reg;
        long_done_next = long_done_reg;
        armed_next     = armed_reg;
        ev_next        = bdsl_pkg::EV_NONE;
        if (!started_reg)
        begin
            // first tick seeds the levels
            started_next   = 1'b1;
            last_next      = raw;
            stable_next    = raw;
            quiet_next     = 8'd0;
            press_next     = 16'd0;
            long_done_next = 1'b0;
            armed_next     = !raw;
        end
        else
        begin
            press_next = press_inc;
            if (raw != last_reg)
            begin
                last_next  = raw;
                quiet_next = 8'd0;
            end
            else
            begin
                quiet_next = quiet_inc;
                if (quiet_inc >= debounce_reg)
                begin
                    if (raw == stable_reg)
                    begin
                        if (stable_reg && armed_reg && !long_done_reg && press_inc >= long_reg)
                        begin
                            long_done_next = 1'b1;
                            ev_next        = bdsl_pkg::EV_LONG;
                        end
                    end
                    else
                    begin
                        stable_next = raw;
                        if (raw)
                        begin
                            press_next     = 16'd0;
                            long_done_next = 1'b0;
                            ev_next        = armed_reg ? bdsl_pkg::EV_PRESSED
                                                       : bdsl_pkg::EV_NONE;
                        end
                        else if (!armed_reg)
                        begin
                            armed_next = 1'b1;
                            ev_next    = bdsl_pkg::EV_ARMED;
                        end
                        else if (long_done_reg)
                        begin
                            long_done_next = 1'b0;
                        end
                        else
                        begin
                            ev_next = bdsl_pkg::EV_SHORT;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            last_reg      <= 1'b0;
            stable_reg    <= 1'b0;
            quiet_reg     <= 8'd0;
            press_reg     <= 16'd0;
            long_done_reg <= 1'b0;
            armed_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                started_reg   <= started_next;
                last_reg      <= last_next;
                stable_reg    <= stable_next;
                quiet_reg     <= quiet_next;
                press_reg     <= press_next;
                long_done_reg <= long_done_next;
                armed_reg     <= armed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ev_reg <= ev_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign event_res    = ev_reg;
    // state registers carry the post-tick values of the last transfer
    assign held_ms      = press_reg;
    assign stable_level = stable_reg;

endmodule

[hw/rtl/button_debounce_short_long_press_top.sv]
// an input transfer reaches its result through the input register, then the result register
// throughput: one tick per cycle while out_stall is low, set by the state update in the core
// a result waiting on out_stall still lets one more tick enter the input register
// reset (rst_n, async, active low): all tick state cleared, config to defaults
// depends on bdsl_pkg, bdsl_in_stage, bdsl_core
module button_debounce_short_long_press_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // tick input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            button_down,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [bdsl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdsl_pkg::CFG_DATA_W-1:0] cfg_data,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      event_res,
    output logic [15:0]                     held_ms,
    output logic                            stable_level
);

    bdsl_pkg::stage_t item;
    logic             take;

    // input register: one tick transfer waits here for the core
    bdsl_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .button_down (button_down),
        .take        (take),
        .item        (item)
    );

    // debounce, press timer and event decode, then the result register
    bdsl_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .take         (take),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .held_ms      (held_ms),
        .stable_level (stable_level)
    );

    // the input side only backs up when a result is held by the sink
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // a press event restarts the timer and shows a pressed level
    a_press_held : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == bdsl_pkg::EV_PRESSED) |-> (held_ms == 16'd0 && stable_level))
        else $error("press event without timer restart");

    // long press only fires while the debounced level is down
    a_long_level : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == bdsl_pkg::EV_LONG) |-> stable_level)
        else $error("long press with button released");

    // short press and arming come with a released level
    a_release_level : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == bdsl_pkg::EV_SHORT || event_res == bdsl_pkg::EV_ARMED))
        |-> !stable_level)
        else $error("release event with button down");

endmodule
